// ===== design/tmss_pkg.sv =====
// shared types and constants for the tick momentum / spread signal core
// no dependencies
package tmss_pkg;

	localparam int DEF_PRICE_BITS = 32;
	localparam int REG_BITS       = 32;
	localparam int CFG_IDX_BITS   = 4;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_THR  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPREAD_THR = CFG_IDX_BITS'(1);

	localparam logic [REG_BITS-1:0] ACCEL_THR_RST  = REG_BITS'(500);
	localparam logic [REG_BITS-1:0] SPREAD_THR_RST = REG_BITS'(100);

	typedef enum logic [1:0] {
		DEC_BUY  = 2'd0,
		DEC_SELL = 2'd1,
		DEC_WAIT = 2'd2
	} dec_t;

	// stage 1 status handed to the evaluation stage
	typedef struct packed {
		logic valid;
		logic warm;
	} tmss_ctl_t;

endpackage

// ===== design/tmss_hist.sv =====
// input stage: bid/spread history, warm-up count and the stage 1 register
// depends on tmss_pkg
module tmss_hist import tmss_pkg::*; #(
	parameter int PRICE_BITS = DEF_PRICE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PRICE_BITS-1:0] quote_bid,
	input  logic [PRICE_BITS-1:0] quote_ask,
	input  logic                  take,
	output tmss_ctl_t             ctl_s1,
	output logic [PRICE_BITS-1:0] bid_s1,
	output logic [PRICE_BITS-1:0] pbid_s1,
	output logic [PRICE_BITS-1:0] obid_s1,
	output logic [PRICE_BITS:0]   pspr_s1,
	output logic [PRICE_BITS:0]   ospr_s1
);

	logic                  accept;
	logic [1:0]            ticks_q;
	logic [PRICE_BITS-1:0] pbid_q;
	logic [PRICE_BITS-1:0] obid_q;
	logic [PRICE_BITS:0]   pspr_q;
	logic [PRICE_BITS:0]   ospr_q;
	logic [PRICE_BITS:0]   spread;

	assign in_ready = !ctl_s1.valid || take;
	assign accept   = in_valid && in_ready;
	assign spread   = {1'b0, quote_ask} - {1'b0, quote_bid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q      <= 2'd0;
			ctl_s1.valid <= 1'b0;
			ctl_s1.warm  <= 1'b0;
		end else begin
			if (accept) begin
				ctl_s1.valid <= 1'b1;
				ctl_s1.warm  <= (ticks_q == 2'd2);
				if (ticks_q != 2'd2) begin
					ticks_q <= ticks_q + 2'd1;
				end
			end else if (take) begin
				ctl_s1.valid <= 1'b0;
			end
		end
	end

	// history and stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			bid_s1  <= quote_bid;
			pbid_s1 <= pbid_q;
			obid_s1 <= obid_q;
			pspr_s1 <= pspr_q;
			ospr_s1 <= ospr_q;
			obid_q  <= pbid_q;
			pbid_q  <= quote_bid;
			ospr_q  <= pspr_q;
			pspr_q  <= spread;
		end
	end

endmodule

// ===== design/tmss_eval.sv =====
// evaluation stage: acceleration, filtered spread, decision and result register
// depends on tmss_pkg
module tmss_eval import tmss_pkg::*; #(
	parameter int PRICE_BITS = DEF_PRICE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmss_ctl_t             ctl_s1,
	input  logic [PRICE_BITS-1:0] bid_s1,
	input  logic [PRICE_BITS-1:0] pbid_s1,
	input  logic [PRICE_BITS-1:0] obid_s1,
	input  logic [PRICE_BITS:0]   pspr_s1,
	input  logic [PRICE_BITS:0]   ospr_s1,
	input  logic [REG_BITS-1:0]   accel_thr,
	input  logic [REG_BITS-1:0]   spread_thr,
	output logic                  take,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            decision,
	output logic [PRICE_BITS+1:0] acceleration,
	output logic [PRICE_BITS+4:0] filtered_spread_x10,
	output logic                  ready_res
);

	localparam int ACC_BITS = PRICE_BITS + 2;
	localparam int FS_BITS  = PRICE_BITS + 5;
	localparam int THR_BITS = REG_BITS + 4;
	localparam int CMP_BITS = ((FS_BITS > THR_BITS) ? FS_BITS : THR_BITS) + 2;

	logic signed [ACC_BITS-1:0] accel_c;
	logic signed [FS_BITS-1:0]  pspr_x;
	logic signed [FS_BITS-1:0]  ospr_x;
	logic signed [FS_BITS-1:0]  fs_c;
	logic signed [CMP_BITS-1:0] acc_w;
	logic signed [CMP_BITS-1:0] fs_w;
	logic signed [CMP_BITS-1:0] athr_w;
	logic signed [CMP_BITS-1:0] sthr_w;
	logic signed [CMP_BITS-1:0] sthr10_w;
	logic                       wide;
	dec_t                       dec_c;
	dec_t                       dec_q;

	assign take = !out_valid || out_ready;

	assign accel_c = {2'b00, bid_s1} - {1'b0, pbid_s1, 1'b0} + {2'b00, obid_s1};
	assign pspr_x  = {{(FS_BITS-PRICE_BITS-1){pspr_s1[PRICE_BITS]}}, pspr_s1};
	assign ospr_x  = {{(FS_BITS-PRICE_BITS-1){ospr_s1[PRICE_BITS]}}, ospr_s1};
	// 7 * previous + 3 * older
	assign fs_c    = (pspr_x <<< 3) - pspr_x + (ospr_x <<< 1) + ospr_x;

	assign acc_w    = {{(CMP_BITS-ACC_BITS){accel_c[ACC_BITS-1]}}, accel_c};
	assign fs_w     = {{(CMP_BITS-FS_BITS){fs_c[FS_BITS-1]}}, fs_c};
	assign athr_w   = {{(CMP_BITS-REG_BITS){1'b0}}, accel_thr};
	assign sthr_w   = {{(CMP_BITS-REG_BITS){1'b0}}, spread_thr};
	assign sthr10_w = (sthr_w <<< 3) + (sthr_w <<< 1);
	assign wide     = fs_w > sthr10_w;

	always_comb begin
		dec_c = DEC_WAIT;
		if (ctl_s1.warm && wide) begin
			if (acc_w > athr_w) begin
				dec_c = DEC_BUY;
			end else if (acc_w < -athr_w) begin
				dec_c = DEC_SELL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctl_s1.valid) begin
			dec_q               <= dec_c;
			ready_res           <= ctl_s1.warm;
			acceleration        <= ctl_s1.warm ? accel_c : '0;
			filtered_spread_x10 <= ctl_s1.warm ? fs_c : '0;
		end
	end

	assign decision = dec_q;

endmodule

// ===== design/tick_momentum_spread_signal_core.sv =====
// top level of the tick momentum / spread signal core
// depends on tmss_pkg, tmss_hist, tmss_eval
//
// channel   handshake               payload
// in        in_valid / in_ready     quote_bid, quote_ask
// out       out_valid / out_ready   decision, acceleration, filtered_spread_x10, ready_res
// cfg       cfg_we                  cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready is high
// an accepted item passes the two-register path: history/input stage then evaluation stage
// reset clears thresholds to defaults, the tick count and both valid flags
// a stalled result holds the evaluation stage; the input stage still fills once
// the first two ticks after reset give wait with ready_res low
module tick_momentum_spread_signal_core import tmss_pkg::*; #(
	parameter int PRICE_BITS = DEF_PRICE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PRICE_BITS-1:0]   quote_bid,
	input  logic [PRICE_BITS-1:0]   quote_ask,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              decision,
	output logic [PRICE_BITS+1:0]   acceleration,
	output logic [PRICE_BITS+4:0]   filtered_spread_x10,
	output logic                    ready_res,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]     cfg_wdata
);

	logic [REG_BITS-1:0]   accel_thr_q;
	logic [REG_BITS-1:0]   spread_thr_q;
	tmss_ctl_t             ctl_s1;
	logic                  take;
	logic [PRICE_BITS-1:0] bid_s1;
	logic [PRICE_BITS-1:0] pbid_s1;
	logic [PRICE_BITS-1:0] obid_s1;
	logic [PRICE_BITS:0]   pspr_s1;
	logic [PRICE_BITS:0]   ospr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_thr_q  <= ACCEL_THR_RST;
			spread_thr_q <= SPREAD_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACCEL_THR:  accel_thr_q  <= cfg_wdata;
				CFG_SPREAD_THR: spread_thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tmss_hist #(.PRICE_BITS(PRICE_BITS)) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quote_bid (quote_bid),
		.quote_ask (quote_ask),
		.take      (take),
		.ctl_s1    (ctl_s1),
		.bid_s1    (bid_s1),
		.pbid_s1   (pbid_s1),
		.obid_s1   (obid_s1),
		.pspr_s1   (pspr_s1),
		.ospr_s1   (ospr_s1)
	);

	tmss_eval #(.PRICE_BITS(PRICE_BITS)) u_eval (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctl_s1              (ctl_s1),
		.bid_s1              (bid_s1),
		.pbid_s1             (pbid_s1),
		.obid_s1             (obid_s1),
		.pspr_s1             (pspr_s1),
		.ospr_s1             (ospr_s1),
		.accel_thr           (accel_thr_q),
		.spread_thr          (spread_thr_q),
		.take                (take),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.decision            (decision),
		.acceleration        (acceleration),
		.filtered_spread_x10 (filtered_spread_x10),
		.ready_res           (ready_res)
	);

endmodule

// ===== design/tmss_chk.sv =====
// port-level checks for the tick momentum / spread signal core, bound to the top level
// depends on tmss_pkg and tick_momentum_spread_signal_core
module tmss_chk import tmss_pkg::*; #(
	parameter int PRICE_BITS = DEF_PRICE_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            decision,
	input logic [PRICE_BITS+1:0] acceleration,
	input logic [PRICE_BITS+4:0] filtered_spread_x10,
	input logic                  ready_res
);

	// a stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out item dropped while stalled");

	// warm-up items are wait with zero fields
	a_warm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ready_res |-> decision == DEC_WAIT && acceleration == '0
			&& filtered_spread_x10 == '0)
		else $error("warm-up item not neutral");

	// buy needs rising, sell falling acceleration, both a non-negative spread
	a_buy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decision == DEC_BUY |-> ready_res && !acceleration[PRICE_BITS+1]
			&& !filtered_spread_x10[PRICE_BITS+4] && acceleration != '0)
		else $error("buy without positive acceleration");

	a_sell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decision == DEC_SELL |-> ready_res && acceleration[PRICE_BITS+1]
			&& !filtered_spread_x10[PRICE_BITS+4])
		else $error("sell without negative acceleration");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> decision == DEC_BUY || decision == DEC_SELL || decision == DEC_WAIT)
		else $error("undefined decision code");

endmodule

bind tick_momentum_spread_signal_core tmss_chk #(.PRICE_BITS(PRICE_BITS)) u_chk (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.decision            (decision),
	.acceleration        (acceleration),
	.filtered_spread_x10 (filtered_spread_x10),
	.ready_res           (ready_res)
);
